// ===== rtl/rhc_pkg.sv =====
package rhc_pkg;

   // channel and datapath widths
   localparam int RHC_CH_W  = 8;
   localparam int RHC_NUM_W = 16;
   localparam int RHC_HNUM_W = 14;
   localparam int RHC_QUO_W = 8;

   // default depth of the queue between front and back
   localparam int RHC_QUEUE_DEPTH = 4;

   // hue offsets per dominant channel and scale factors
   localparam int RHC_OFS_RED   = 0;
   localparam int RHC_OFS_GREEN = 85;
   localparam int RHC_OFS_BLUE  = 171;
   localparam int RHC_HUE_SCALE = 43;
   localparam int RHC_SAT_SCALE = 255;

   // classified pixel handed from front to back
   typedef struct packed {
      logic [RHC_CH_W-1:0]   mx;
      logic [RHC_CH_W-1:0]   d;
      logic [RHC_CH_W-1:0]   offset;
      logic                  neg;
      logic [RHC_NUM_W-1:0]  sat_num;
      logic [RHC_HNUM_W-1:0] hue_num;
   } pix_type;

endpackage

// ===== rtl/rgb_to_hsv_converter.sv =====
// RGB to HSV pixel converter, 8 bits per channel.
// Path: the front register, the queue, eight divider stages and the output register lie between start and rsp_valid.
// Throughput: one pixel per cycle while busy is low, through the eight-stage pipelined divider pair.
// busy stays low in operation since the back end drains the queue every cycle.
// Reset: synchronous, active high; clears valid bits, queue pointers and fill level only.
// The receiver cannot stall: each result is on the rsp_ ports for one cycle.
module rgb_to_hsv_converter #(
   parameter int QUEUE_DEPTH = rhc_pkg::RHC_QUEUE_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [rhc_pkg::RHC_CH_W-1:0] req_red,
   input  logic [rhc_pkg::RHC_CH_W-1:0] req_green,
   input  logic [rhc_pkg::RHC_CH_W-1:0] req_blue,
   output logic                         rsp_valid,
   output logic [rhc_pkg::RHC_CH_W-1:0] rsp_hue,
   output logic [rhc_pkg::RHC_CH_W-1:0] rsp_saturation,
   output logic [rhc_pkg::RHC_CH_W-1:0] rsp_brightness
);
   import rhc_pkg::*;

   logic    accept;
   logic    front_valid;
   pix_type front_pix;
   logic    queue_valid;
   pix_type queue_pix;
   logic    queue_almost_full;

   // take a beat when start meets a free queue slot
   assign accept = start && !busy;
   assign busy   = queue_almost_full;

   rhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .out_valid (front_valid),
      .out_pix   (front_pix)
   );

   rhc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (front_valid),
      .push_pix    (front_pix),
      .pop_valid   (queue_valid),
      .pop_pix     (queue_pix),
      .almost_full (queue_almost_full)
   );

   rhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (queue_valid),
      .in_pix     (queue_pix),
      .out_valid  (rsp_valid),
      .out_hue    (rsp_hue),
      .out_sat    (rsp_saturation),
      .out_bright (rsp_brightness)
   );

endmodule

// ===== rtl/rhc_front.sv =====
module rhc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  logic [rhc_pkg::RHC_CH_W-1:0] red,
   input  logic [rhc_pkg::RHC_CH_W-1:0] green,
   input  logic [rhc_pkg::RHC_CH_W-1:0] blue,
   output logic                     out_valid,
   output rhc_pkg::pix_type         out_pix
);
   import rhc_pkg::*;

   logic [RHC_CH_W-1:0] mx;
   logic [RHC_CH_W-1:0] mn;
   logic signed [RHC_CH_W:0] diff;
   logic [RHC_CH_W:0]   mag_wide;
   pix_type             pix_in;
   pix_type             pix_ff;
   logic                valid_ff;
   logic                valid_in;

   // find extremes and classify the dominant channel; red wins ties, then green
   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;

      priority if (mx == red) begin
         diff          = $signed({1'b0, green}) - $signed({1'b0, blue});
         pix_in.offset = RHC_CH_W'(RHC_OFS_RED);
      end else if (mx == green) begin
         diff          = $signed({1'b0, blue}) - $signed({1'b0, red});
         pix_in.offset = RHC_CH_W'(RHC_OFS_GREEN);
      end else begin
         diff          = $signed({1'b0, red}) - $signed({1'b0, green});
         pix_in.offset = RHC_CH_W'(RHC_OFS_BLUE);
      end

      mag_wide       = diff[RHC_CH_W] ? 9'(-diff) : 9'(diff);
      pix_in.mx      = mx;
      pix_in.d       = mx - mn;
      pix_in.neg     = diff[RHC_CH_W];
      pix_in.sat_num = RHC_NUM_W'({8'b0, pix_in.d} * 16'(RHC_SAT_SCALE));
      pix_in.hue_num = RHC_HNUM_W'({6'b0, mag_wide[RHC_CH_W-1:0]} * 14'(RHC_HUE_SCALE));
   end

   assign valid_in = in_valid;

   // register the classified beat
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pix_ff <= pix_in;
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;

endmodule

// ===== rtl/rhc_queue.sv =====
module rhc_queue #(
   parameter int DEPTH = rhc_pkg::RHC_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rhc_pkg::pix_type push_pix,
   output logic             pop_valid,
   output rhc_pkg::pix_type pop_pix,
   output logic             almost_full
);
   import rhc_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   pix_type           mem [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   // back end drains one beat every cycle something is queued
   assign pop       = (count_ff != '0);
   assign pop_valid = pop;
   assign pop_pix   = mem[rd_ptr_ff];

   // leave room for the beat already in the front register
   assign almost_full = (count_ff >= CNT_W'(DEPTH - 1));

   // advance pointers with wrap and track the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed beat
   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_pix;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill level above depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && (count_ff == CNT_W'(DEPTH)) |-> pop)
      else $error("push into full queue");
`endif

endmodule

// ===== rtl/rhc_back.sv =====
module rhc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  rhc_pkg::pix_type             in_pix,
   output logic                         out_valid,
   output logic [rhc_pkg::RHC_CH_W-1:0] out_hue,
   output logic [rhc_pkg::RHC_CH_W-1:0] out_sat,
   output logic [rhc_pkg::RHC_CH_W-1:0] out_bright
);
   import rhc_pkg::*;

   localparam int NUM_STAGES = RHC_QUO_W;

   typedef struct packed {
      logic [RHC_CH_W-1:0]  mx;
      logic [RHC_CH_W-1:0]  d;
      logic [RHC_CH_W-1:0]  offset;
      logic                 neg;
      logic [RHC_NUM_W-1:0] sat_rem;
      logic [RHC_QUO_W-1:0] sat_quo;
      logic [RHC_NUM_W-1:0] hue_rem;
      logic [RHC_QUO_W-1:0] hue_quo;
   } stage_type;

   stage_type             src      [NUM_STAGES];
   stage_type             stage_in [NUM_STAGES];
   stage_type             stage_ff [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;
   stage_type             last;
   logic [RHC_CH_W-1:0]   hue_in, sat_in;
   logic [RHC_CH_W-1:0]   hue_ff, sat_ff, bright_ff;
   logic                  out_valid_ff;

   // load the dividends; quotients start empty
   always_comb begin
      src[0].mx      = in_pix.mx;
      src[0].d       = in_pix.d;
      src[0].offset  = in_pix.offset;
      src[0].neg     = in_pix.neg;
      src[0].sat_rem = in_pix.sat_num;
      src[0].sat_quo = '0;
      src[0].hue_rem = RHC_NUM_W'(in_pix.hue_num);
      src[0].hue_quo = '0;
   end

   // one restoring division step per stage, both dividers side by side
   for (genvar i = 0; i < NUM_STAGES; i++) begin : g_stage
      localparam int SHIFT = NUM_STAGES - 1 - i;
      logic [RHC_NUM_W-1:0] sat_div, hue_div;
      logic [RHC_NUM_W:0]   sat_trial, hue_trial;

      if (i > 0) begin : g_link
         assign src[i] = stage_ff[i-1];
      end

      always_comb begin
         stage_in[i] = src[i];
         sat_div     = RHC_NUM_W'({8'b0, src[i].mx}) << SHIFT;
         hue_div     = RHC_NUM_W'({8'b0, src[i].d}) << SHIFT;
         sat_trial   = {1'b0, src[i].sat_rem} - {1'b0, sat_div};
         hue_trial   = {1'b0, src[i].hue_rem} - {1'b0, hue_div};
         if (!sat_trial[RHC_NUM_W]) begin
            stage_in[i].sat_rem        = sat_trial[RHC_NUM_W-1:0];
            stage_in[i].sat_quo[SHIFT] = 1'b1;
         end
         if (!hue_trial[RHC_NUM_W]) begin
            stage_in[i].hue_rem        = hue_trial[RHC_NUM_W-1:0];
            stage_in[i].hue_quo[SHIFT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[i] <= stage_in[i];
      end
   end

   // advance valid bits down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], in_valid};
      end
   end

   // apply sign and offset; zero spread means grey or black
   assign last = stage_ff[NUM_STAGES-1];
   always_comb begin
      if (last.d == '0) begin
         hue_in = '0;
         sat_in = '0;
      end else begin
         hue_in = last.offset + (last.neg ? RHC_CH_W'(-last.hue_quo) : last.hue_quo);
         sat_in = last.sat_quo;
      end
   end

   // drive the result beat for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[NUM_STAGES-1];
      end
      hue_ff    <= hue_in;
      sat_ff    <= sat_in;
      bright_ff <= last.mx;
   end

   assign out_valid  = out_valid_ff;
   assign out_hue    = hue_ff;
   assign out_sat    = sat_ff;
   assign out_bright = bright_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      in_valid |-> ##(NUM_STAGES + 1) out_valid)
      else $error("beat lost in divider pipe");
   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      out_valid && (out_sat == '0) |-> (out_hue == '0))
      else $error("hue nonzero with zero saturation");
`endif

endmodule
